// ===== hdl/pbrd_pkg.sv =====
// Package: shared types and constants for the planar PackBits row decoder.
`timescale 1ns / 1ps
package pbrd_pkg;

  localparam int MAX_ROW_BYTES = 256;
  localparam int MAX_PLANES    = 8;
  localparam int BUDGET_W      = $clog2(MAX_ROW_BYTES + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] HDR_NOP = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_ROW   = 3'd0,
    CFG_PLANE_COUNT     = 3'd1,
    CFG_ROW_COUNT       = 3'd2,
    CFG_COMPRESSED_MODE = 3'd3,
    CFG_DEST_X          = 3'd4,
    CFG_DEST_Y          = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_LIT    = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] bytes_per_row;
    logic [3:0] plane_count;
    logic [9:0] row_count;
    logic       compressed_mode;
    logic [9:0] dest_x;
    logic [9:0] dest_y;
  } cfg_t;

  // Record handed from the decoder front to the address back end.
  typedef struct packed {
    logic [7:0] value;
    logic [2:0] plane;
    logic [9:0] row;
    logic [7:0] column;
    logic [7:0] count;
    logic       done;
    logic       error;
  } rec_t;

endpackage

// ===== hdl/pbrd_if.sv =====
// Interfaces: encoded byte channel and run record channel.
`timescale 1ns / 1ps
interface pbrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface pbrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  plane_byte;
  logic [2:0]  plane_index;
  logic [10:0] out_row;
  logic [11:0] out_column;
  logic [7:0]  repeat_count;
  logic        image_done;
  logic        format_error;

  modport source (output valid, output plane_byte, output plane_index, output out_row,
                  output out_column, output repeat_count, output image_done,
                  output format_error, input ready);
  modport sink   (input valid, input plane_byte, input plane_index, input out_row,
                  input out_column, input repeat_count, input image_done,
                  input format_error, output ready);
endinterface

// ===== hdl/planar_packbits_row_decoder.sv =====
// Top level: planar PackBits row decoder with configuration registers.
// Takes one encoded byte per clock cycle with no bubbles while the record queue
// is not full, for headers, run values and literals alike; each byte needs only
// counter updates in the decoder front. A run record passes through the record
// queue and then the output register before it reaches the output. The two-entry
// queue and the output register absorb output stalls, so input ready drops only
// once both queue entries hold records the output has not yet taken.
`timescale 1ns / 1ps
module planar_packbits_row_decoder
  import pbrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pbrd_in_if.sink               in_if,
  pbrd_out_if.source            out_if
);

  cfg_t cfg_q;
  logic push;
  rec_t push_rec;
  logic q_full;
  logic q_valid;
  logic pop;
  rec_t pop_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_row   <= 8'd1;
      cfg_q.plane_count     <= 4'd4;
      cfg_q.row_count       <= 10'd1;
      cfg_q.compressed_mode <= 1'b1;
      cfg_q.dest_x          <= 10'd0;
      cfg_q.dest_y          <= 10'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BYTES_PER_ROW:   cfg_q.bytes_per_row   <= cfg_data_i[7:0];
        CFG_PLANE_COUNT:     cfg_q.plane_count     <= cfg_data_i[3:0];
        CFG_ROW_COUNT:       cfg_q.row_count       <= cfg_data_i[9:0];
        CFG_COMPRESSED_MODE: cfg_q.compressed_mode <= cfg_data_i[0];
        CFG_DEST_X:          cfg_q.dest_x          <= cfg_data_i[9:0];
        CFG_DEST_Y:          cfg_q.dest_y          <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  pbrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .data_byte_i  (in_if.data_byte),
    .first_byte_i (in_if.first_byte),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  pbrd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_rec)
  );

  pbrd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (pop_rec),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule

// ===== hdl/pbrd_front.sv =====
// Decoder front: parses headers, tracks budget and position, emits run records.
`timescale 1ns / 1ps
module pbrd_front
  import pbrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output rec_t       rec_o
);

  phase_e                phase_q, phase_d;
  logic [BUDGET_W-1:0]   budget_q, budget_d;
  logic [7:0]            pend_q, pend_d;
  logic [2:0]            plane_q, plane_d;
  logic [9:0]            row_q, row_d;
  logic [7:0]            col_q, col_d;
  logic                  drop_q, drop_d;
  logic                  err_q, err_d;

  logic [7:0]            base_bpr;
  logic [8:0]            even_bpr;
  logic [BUDGET_W-1:0]   full_budget;
  logic [3:0]            planes_eff;
  logic [9:0]            rows_eff;
  logic                  odd;
  logic                  accept;

  always_comb begin
    base_bpr = (cfg_i.bytes_per_row == 8'd0) ? 8'd1 : cfg_i.bytes_per_row;
    odd      = base_bpr[0];
    even_bpr = ({1'b0, base_bpr} + 9'd1) & 9'h1FE;
    if (BUDGET_W'(even_bpr) > BUDGET_W'(MAX_ROW_BYTES)) begin
      full_budget = BUDGET_W'(MAX_ROW_BYTES);
    end else begin
      full_budget = BUDGET_W'(even_bpr);
    end
    if (cfg_i.plane_count == 4'd0) begin
      planes_eff = 4'd1;
    end else if (cfg_i.plane_count > 4'(MAX_PLANES)) begin
      planes_eff = 4'(MAX_PLANES);
    end else begin
      planes_eff = cfg_i.plane_count;
    end
    rows_eff = (cfg_i.row_count == 10'd0) ? 10'd1 : cfg_i.row_count;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic                lrp;
    logic                adv;
    logic                do_lit;
    logic                emit;
    logic [8:0]          n0;
    logic [BUDGET_W-1:0] n;
    logic [3:0]          pl_inc;
    logic [10:0]         rw_inc;

    phase_d  = phase_q;
    budget_d = budget_q;
    pend_d   = pend_q;
    plane_d  = plane_q;
    row_d    = row_q;
    col_d    = col_q;
    drop_d   = drop_q;
    err_d    = err_q;
    adv      = 1'b0;
    do_lit   = 1'b0;
    emit     = 1'b0;
    n0       = '0;
    n        = '0;
    pl_inc   = '0;
    rw_inc   = '0;
    rec_o    = '0;

    if (first_byte_i) begin
      phase_d  = PH_HEADER;
      budget_d = '0;
      pend_d   = '0;
      plane_d  = '0;
      row_d    = '0;
      col_d    = '0;
      drop_d   = 1'b0;
      err_d    = 1'b0;
    end

    lrp = ({1'b0, plane_d} + 4'd1 >= planes_eff) &&
          ({1'b0, row_d} + 11'd1 >= {1'b0, rows_eff});

    rec_o.value  = data_byte_i;
    rec_o.plane  = plane_d;
    rec_o.row    = row_d;
    rec_o.column = col_d;

    case (phase_d)
      PH_DONE: begin
      end
      PH_RUN: begin
        phase_d = PH_HEADER;
        if (pend_d != 8'd0) begin
          emit        = 1'b1;
          rec_o.count = pend_d;
          rec_o.done  = (budget_d == '0) && lrp;
          col_d       = col_d + pend_d;
        end
        adv = (budget_d == '0);
      end
      PH_LIT: begin
        do_lit = 1'b1;
      end
      PH_HEADER: begin
        if (budget_d == '0) begin
          budget_d = full_budget;
        end
        if (!cfg_i.compressed_mode) begin
          // raw row: whole budget is one literal, no header byte
          pend_d   = 8'(budget_d - BUDGET_W'(1));
          budget_d = '0;
          drop_d   = odd;
          phase_d  = PH_LIT;
          do_lit   = 1'b1;
        end else if (data_byte_i == HDR_NOP) begin
          budget_d = budget_d - BUDGET_W'(1);
          adv      = (budget_d == '0);
        end else begin
          if (data_byte_i > HDR_NOP) begin
            n0 = 9'd257 - {1'b0, data_byte_i};
          end else begin
            n0 = {1'b0, data_byte_i} + 9'd1;
          end
          n = BUDGET_W'(n0);
          if (n > budget_d) begin
            err_d = 1'b1;
            n     = budget_d;
          end
          budget_d = budget_d - n;
          if (data_byte_i > HDR_NOP) begin
            // odd width: pad byte at the end of the row is not drawn
            if (budget_d == '0 && odd) begin
              n = n - BUDGET_W'(1);
            end
            pend_d  = 8'(n);
            phase_d = PH_RUN;
          end else begin
            drop_d  = (budget_d == '0) && odd;
            pend_d  = 8'(n - BUDGET_W'(1));
            phase_d = PH_LIT;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_lit) begin
      rec_o.count = 8'd1;
      if (pend_d == 8'd0) begin
        phase_d = PH_HEADER;
        if (!drop_d) begin
          emit       = 1'b1;
          rec_o.done = (budget_d == '0) && lrp;
          col_d      = col_d + 8'd1;
        end
        adv = (budget_d == '0);
      end else begin
        emit       = 1'b1;
        rec_o.done = (budget_d == '0) && lrp && (pend_d == 8'd1) && drop_d;
        col_d      = col_d + 8'd1;
        pend_d     = pend_d - 8'd1;
      end
    end

    rec_o.error = err_d;

    if (adv) begin
      col_d  = '0;
      pl_inc = {1'b0, plane_d} + 4'd1;
      if (pl_inc >= planes_eff) begin
        plane_d = '0;
        rw_inc  = {1'b0, row_d} + 11'd1;
        row_d   = rw_inc[9:0];
        if (rw_inc >= {1'b0, rows_eff}) begin
          phase_d = PH_DONE;
        end
      end else begin
        plane_d = pl_inc[2:0];
      end
    end

    push_o = accept && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      budget_q <= '0;
      pend_q   <= '0;
      plane_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      drop_q   <= 1'b0;
      err_q    <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      budget_q <= budget_d;
      pend_q   <= pend_d;
      plane_q  <= plane_d;
      row_q    <= row_d;
      col_q    <= col_d;
      drop_q   <= drop_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== hdl/pbrd_queue.sv =====
// Short record queue between decoder front and address back end.
`timescale 1ns / 1ps
module pbrd_queue
  import pbrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output rec_t pop_data_o
);

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/pbrd_back.sv =====
// Back end: forms destination row and column and holds the output record.
`timescale 1ns / 1ps
module pbrd_back
  import pbrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  rec_t  q_data_i,
  output logic  pop_o,
  pbrd_out_if.source out_if
);

  logic        out_valid_q;
  logic [7:0]  value_q;
  logic [2:0]  plane_q;
  logic [10:0] row_q;
  logic [11:0] column_q;
  logic [7:0]  count_q;
  logic        done_q;
  logic        error_q;

  assign pop_o = q_valid_i && (!out_valid_q || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q  <= q_data_i.value;
      plane_q  <= q_data_i.plane;
      row_q    <= {1'b0, cfg_i.dest_y} + {1'b0, q_data_i.row};
      column_q <= {2'b00, cfg_i.dest_x} + {1'b0, q_data_i.column, 3'b000};
      count_q  <= q_data_i.count;
      done_q   <= q_data_i.done;
      error_q  <= q_data_i.error;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.plane_byte   = value_q;
  assign out_if.plane_index  = plane_q;
  assign out_if.out_row      = row_q;
  assign out_if.out_column   = column_q;
  assign out_if.repeat_count = count_q;
  assign out_if.image_done   = done_q;
  assign out_if.format_error = error_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the planar PackBits row decoder: directed and random images vs. a predictor.
`timescale 1ns / 1ps
module testbench;
  import pbrd_pkg::*;

  localparam int HOLD_CYCLES    = 100;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0]  value;
    logic [2:0]  plane;
    logic [10:0] row;
    logic [11:0] column;
    logic [7:0]  count;
    logic        done;
    logic        error;
  } run_rec_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pbrd_in_if  byte_bus ();
  pbrd_out_if run_bus ();

  planar_packbits_row_decoder dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_if  (byte_bus),
    .out_if (run_bus)
  );

  // Register copies seen by the predictor
  logic [7:0] reg_bpr;
  logic [3:0] reg_planes;
  logic [9:0] reg_rows;
  logic       reg_compressed;
  logic [9:0] reg_dest_x;
  logic [9:0] reg_dest_y;

  // Decoder position and header state
  phase_e     dec_phase;
  logic [8:0] row_left;
  logic [7:0] bytes_owed;
  logic [2:0] cur_plane;
  logic [9:0] cur_row;
  logic [7:0] cur_col;
  logic       skip_pad;
  logic       err_sticky;

  run_rec_t   due_records[$];
  run_rec_t   seen_rec;
  run_rec_t   want_rec;
  int         mismatches = 0;
  int         decoded_items = 0;
  int         send_idle_pct = 16;
  int         take_idle_pct = 74;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  bit         new_image = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_bpr();
    return (reg_bpr == 0) ? 1 : reg_bpr;
  endfunction

  function automatic int unsigned eff_planes();
    if (reg_planes == 0) return 1;
    return (reg_planes > MAX_PLANES) ? MAX_PLANES : reg_planes;
  endfunction

  function automatic int unsigned eff_rows();
    return (reg_rows == 0) ? 1 : reg_rows;
  endfunction

  // Even budget of one row-plane, saturated at the row buffer size
  function automatic int unsigned row_plane_budget();
    int unsigned even;
    even = (eff_bpr() + 1) & ~32'd1;
    return (even > MAX_ROW_BYTES) ? MAX_ROW_BYTES : even;
  endfunction

  function automatic bit on_last_plane();
    return (cur_plane + 1 >= eff_planes()) && (cur_row + 1 >= eff_rows());
  endfunction

  function automatic void next_row_plane();
    cur_col = '0;
    if (cur_plane + 1 >= eff_planes()) begin
      cur_plane = '0;
      cur_row   = cur_row + 1'b1;
      if (cur_row >= eff_rows()) dec_phase = PH_DONE;
    end else begin
      cur_plane = cur_plane + 1'b1;
    end
  endfunction

  function automatic void clear_position();
    dec_phase  = PH_HEADER;
    row_left   = '0;
    bytes_owed = '0;
    cur_plane  = '0;
    cur_row    = '0;
    cur_col    = '0;
    skip_pad   = 1'b0;
    err_sticky = 1'b0;
  endfunction

  function automatic run_rec_t make_record(input logic [7:0] v, input int unsigned n,
                                           input bit done);
    run_rec_t rec;
    rec.value  = v;
    rec.plane  = cur_plane;
    rec.row    = reg_dest_y + cur_row;
    rec.column = reg_dest_x + 8 * cur_col;
    rec.count  = 8'(n);
    rec.done   = done;
    rec.error  = err_sticky;
    return rec;
  endfunction

  // Overlong runs and literals are cut to what is left of the row and flag an error
  function automatic int unsigned clip_to_budget(input int unsigned n);
    if (n > row_left) begin
      err_sticky = 1'b1;
      n = row_left;
    end
    row_left = row_left - 9'(n);
    return n;
  endfunction

  function automatic bit take_literal(input logic [7:0] b, output run_rec_t rec);
    bit emitted;
    emitted = 1'b0;
    rec = '0;
    if (bytes_owed == 0) begin
      dec_phase = PH_HEADER;
      if (!skip_pad) begin
        rec = make_record(b, 1, row_left == 0 && on_last_plane());
        cur_col = cur_col + 1'b1;
        emitted = 1'b1;
      end
      if (row_left == 0) next_row_plane();
    end else begin
      // with a pad byte pending, the byte before it closes the image
      rec = make_record(b, 1, row_left == 0 && on_last_plane() && bytes_owed == 1 && skip_pad);
      cur_col    = cur_col + 1'b1;
      bytes_owed = bytes_owed - 1'b1;
      emitted    = 1'b1;
    end
    return emitted;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input bit first, output run_rec_t rec);
    bit          odd;
    bit          emitted;
    int unsigned n;
    rec = '0;
    emitted = 1'b0;
    if (first) clear_position();
    if (dec_phase == PH_DONE) return 1'b0;
    odd = (eff_bpr() % 2) == 1;

    if (dec_phase == PH_RUN) begin
      n = bytes_owed;
      dec_phase = PH_HEADER;
      if (n > 0) begin
        rec = make_record(b, n, row_left == 0 && on_last_plane());
        cur_col = cur_col + 8'(n);
        emitted = 1'b1;
      end
      if (row_left == 0) next_row_plane();
      return emitted;
    end
    if (dec_phase == PH_LIT) return take_literal(b, rec);

    if (row_left == 0) row_left = 9'(row_plane_budget());

    if (!reg_compressed) begin
      n          = row_left;
      row_left   = '0;
      skip_pad   = odd;
      bytes_owed = 8'(n - 1);
      dec_phase  = PH_LIT;
      return take_literal(b, rec);
    end

    if (b == HDR_NOP) begin
      row_left = row_left - 1'b1;
      if (row_left == 0) next_row_plane();
      return 1'b0;
    end
    if (b > HDR_NOP) begin
      n = clip_to_budget(257 - b);
      if (row_left == 0 && odd) n = n - 1;
      bytes_owed = 8'(n);
      dec_phase  = PH_RUN;
      return 1'b0;
    end
    n          = clip_to_budget(b + 1);
    skip_pad   = (row_left == 0) && odd;
    bytes_owed = 8'(n - 1);
    dec_phase  = PH_LIT;
    return 1'b0;
  endfunction

  function automatic string describe(input run_rec_t r);
    return $sformatf("val=%h plane=%0d row=%0d col=%0d count=%0d done=%b err=%b",
                     r.value, r.plane, r.row, r.column, r.count, r.done, r.error);
  endfunction

  function automatic int unsigned pick_dest();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 0;
    if (pick == 1) return 1023;
    return $urandom_range(0, 1023);
  endfunction

  task automatic send_item(input logic [7:0] b);
    run_rec_t rec;
    bit       ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.data_byte  <= b;
    byte_bus.first_byte <= new_image;
    do @(posedge clk_i); while (!byte_bus.ready);
    ignored = (dec_phase == PH_DONE) && !new_image;
    if (decode_byte(b, new_image, rec)) due_records.push_back(rec);
    if (!ignored) decoded_items++;
    new_image = 1'b0;
  endtask

  // Registers change only once nothing is in flight
  task automatic settle();
    byte_bus.valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned bpr, input int unsigned planes,
                           input int unsigned rows, input int unsigned mode,
                           input int unsigned dx, input int unsigned dy);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BYTES_PER_ROW;
    cfg_data_i  <= CFG_DATA_W'(bpr);
    @(posedge clk_i);
    cfg_index_i <= CFG_PLANE_COUNT;
    cfg_data_i  <= CFG_DATA_W'(planes);
    @(posedge clk_i);
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_data_i  <= CFG_DATA_W'(rows);
    @(posedge clk_i);
    cfg_index_i <= CFG_COMPRESSED_MODE;
    cfg_data_i  <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    cfg_index_i <= CFG_DEST_X;
    cfg_data_i  <= CFG_DATA_W'(dx);
    @(posedge clk_i);
    cfg_index_i <= CFG_DEST_Y;
    cfg_data_i  <= CFG_DATA_W'(dy);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_bpr        = 8'(bpr);
    reg_planes     = 4'(planes);
    reg_rows       = 10'(rows);
    reg_compressed = 1'(mode);
    reg_dest_x     = 10'(dx);
    reg_dest_y     = 10'(dy);
  endtask

  // Mostly well-formed row-planes; some overflows, stray bytes and abandoned images
  task automatic send_image();
    int unsigned left, n, cap, pick, rows_to_send, r, p;
    rows_to_send = (eff_rows() > 3) ? 1 + $urandom_range(1) : eff_rows();
    new_image = 1'b1;
    for (r = 0; r < rows_to_send; r++) begin
      for (p = 0; p < eff_planes(); p++) begin
        if ($urandom_range(49) == 0) return;
        left = row_plane_budget();
        if (!reg_compressed) begin
          repeat (left) send_item(8'($urandom()));
          left = 0;
        end
        while (left > 0) begin
          pick = $urandom_range(99);
          cap  = (left < 128) ? left : 128;
          if (pick < 3) begin
            send_item(8'($urandom()));
            left = left - 1;
          end else if (pick < 10) begin
            send_item(HDR_NOP);
            left = left - 1;
          end else if (pick < 14) begin
            n = left + $urandom_range(1, 8);
            if (n > 128) n = 128;
            if ($urandom_range(1) == 1) begin
              send_item(8'(257 - n));
              send_item(8'($urandom()));
            end else begin
              send_item(8'(n - 1));
              repeat ((n < left) ? n : left) send_item(8'($urandom()));
            end
            left = (n < left) ? left - n : 0;
          end else if (pick < 55 && left >= 2) begin
            n = $urandom_range(2, cap);
            send_item(8'(257 - n));
            send_item(8'($urandom()));
            left = left - n;
          end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(1, cap)
                                         : $urandom_range(1, (cap < 6) ? cap : 6);
            send_item(8'(n - 1));
            repeat (n) send_item(8'($urandom()));
            left = left - n;
          end
        end
      end
    end
    // trailing bytes, which should be dropped if the image has finished
    repeat ($urandom_range(2)) send_item(8'($urandom()));
  endtask

  // Reset registers, no first-byte marker: literal with pad, odd run, skip header,
  // dropped pad, overlong run on the last plane, then a byte after the image
  task automatic test_reset_state();
    send_item(8'h01);
    send_item(8'hA5);
    send_item(8'h5A);
    send_item(8'hFF);
    send_item(8'h00);
    send_item(HDR_NOP);
    send_item(8'h00);
    send_item(8'hFF);
    send_item(8'h81);
    send_item(8'hC3);
    send_item(8'h11);
  endtask

  task automatic test_raw_rows();
    settle();
    configure(3, 1, 1, 0, 1023, 1023);
    new_image = 1'b1;
    send_item(8'hFF);
    send_item(8'h00);
    send_item(8'h80);
    send_item(8'h7F);
  endtask

  // Run that shrinks to nothing, image end without a record, restarts mid-row
  task automatic test_restart_and_empty_run();
    settle();
    configure(1, 1, 1, 1, 0, 0);
    new_image = 1'b1;
    send_item(HDR_NOP);
    send_item(8'hFF);
    send_item(8'h55);
    send_item(8'h33);
    new_image = 1'b1;
    send_item(8'h00);
    send_item(8'h42);
    new_image = 1'b1;
    send_item(8'h7F);
    send_item(8'h99);
    send_item(8'h88);
  endtask

  task automatic test_random_images(input int target, input int send_pct, input int take_pct);
    int          start;
    int unsigned pick, bpr, planes, rows;
    start = decoded_items;
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    while (decoded_items - start < target) begin
      settle();
      pick = $urandom_range(19);
      if (pick == 0)      bpr = 255;
      else if (pick == 1) bpr = 0;
      else if (pick == 2) bpr = $urandom_range(16, 254);
      else                bpr = $urandom_range(1, 6);
      pick = $urandom_range(19);
      if (pick < 2)       planes = 8;
      else if (pick == 2) planes = 0;
      else if (pick == 3) planes = $urandom_range(9, 15);
      else                planes = $urandom_range(1, 4);
      pick = $urandom_range(19);
      if (pick == 0)      rows = 0;
      else if (pick == 1) rows = 1023;
      else                rows = $urandom_range(1, 3);
      if (bpr > 16) begin
        planes = $urandom_range(1, 2);
        rows   = 1;
      end
      configure(bpr, planes, rows, ($urandom_range(4) != 0), pick_dest(), pick_dest());
      send_image();
    end
  endtask

  // Output held off while bytes keep coming, so the record queue fills up
  task automatic test_output_backpressure();
    settle();
    configure(6, 4, 3, 1, 512, 7);
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    send_image();
  endtask

  // Record receiver
  initial begin
    run_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        run_bus.ready <= 1'b0;
      end else begin
        run_bus.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && run_bus.valid && run_bus.ready) begin
      seen_rec = '{value: run_bus.plane_byte, plane: run_bus.plane_index,
                   row: run_bus.out_row, column: run_bus.out_column,
                   count: run_bus.repeat_count, done: run_bus.image_done,
                   error: run_bus.format_error};
      if (due_records.size() == 0) begin
        if (mismatches < 10) $display("%0t: record with none pending: %s", $time,
                                      describe(seen_rec));
        mismatches++;
      end else begin
        want_rec = due_records.pop_front();
        if (seen_rec !== want_rec) begin
          if (mismatches < 10) begin
            $display("%0t: record mismatch", $time);
            $display("  got  %s", describe(seen_rec));
            $display("  want %s", describe(want_rec));
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles in which no request moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_bus.valid && byte_bus.ready) || (run_bus.valid && run_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= CFG_BYTES_PER_ROW;
    cfg_data_i          <= '0;
    byte_bus.valid      <= 1'b0;
    byte_bus.data_byte  <= '0;
    byte_bus.first_byte <= 1'b0;
    reg_bpr        = 8'd1;
    reg_planes     = 4'd4;
    reg_rows       = 10'd1;
    reg_compressed = 1'b1;
    reg_dest_x     = '0;
    reg_dest_y     = '0;
    clear_position();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_raw_rows();
    test_restart_and_empty_run();
    test_random_images(120, 16, 74);
    test_output_backpressure();
    test_random_images(120, 74, 16);
    test_random_images(120, 0, 0);
    settle();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pbrd_pkg.sv
hdl/pbrd_if.sv
hdl/pbrd_front.sv
hdl/pbrd_queue.sv
hdl/pbrd_back.sv
hdl/planar_packbits_row_decoder.sv
tb/sv/testbench.sv
